[sv/jbm_pkg.sv]
// ----------------------------------------------------------------------------
// Jog button multiplier package
// Shared types and constants for the jog button and multiplier controller.
// ----------------------------------------------------------------------------
package jbm_pkg;

   localparam int CFG_W    = 16;
   localparam int CSR_IDX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_TMO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREEZE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_WIN  = 3'd4;

   // Reset values of the configuration registers.
   localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd800;
   localparam logic [CFG_W-1:0] MULT_TMO_RST   = 16'd5000;
   localparam logic [CFG_W-1:0] FREEZE_RST     = 16'd5000;
   localparam logic [CFG_W-1:0] CLICK_WIN_RST  = 16'd1000;

   // Multiplier codes.
   localparam logic [1:0] MULT_OFF  = 2'd0;
   localparam logic [1:0] MULT_X1   = 2'd1;
   localparam logic [1:0] MULT_X10  = 2'd2;
   localparam logic [1:0] MULT_X100 = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE        = 5'b00001,
      PH_DEB_PRESS   = 5'b00010,
      PH_PRESSED     = 5'b00100,
      PH_LONG        = 5'b01000,
      PH_DEB_RELEASE = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
      logic [CFG_W-1:0] multiplier_timeout_ms;
      logic [CFG_W-1:0] freeze_ms;
      logic [CFG_W-1:0] click_window_ms;
   } cfg_type;

   typedef struct packed {
      logic key_down;
      logic spindle_running;
      logic alarm_active;
      logic brake_active;
      logic encoder_moved;
   } req_type;

   typedef struct packed {
      logic [1:0] multiplier_code;
      logic       frozen;
      logic       stop_request;
      logic       display_refresh;
   } rsp_type;

   // Multiplier cycles x1 -> x10 -> x100 -> x1; off also goes to x1.
   function automatic logic [1:0] next_mult(input logic [1:0] m);
      logic [1:0] r;
      case (m)
         MULT_X1:  r = MULT_X10;
         MULT_X10: r = MULT_X100;
         default:  r = MULT_X1;
      endcase
      return r;
   endfunction

endpackage

[sv/jog_button_multiplier_fsm.sv]
// ----------------------------------------------------------------------------
// Jog button multiplier controller
// Debounces the jog key per millisecond tick, manages the jog multiplier,
// display freeze and spindle stop request.
// ----------------------------------------------------------------------------
// Each req_ beat is one millisecond tick. A beat is held in an input register,
// processed by the button state machine and timers, and its result lands in
// an output register; rsp_valid rises as it loads, which waits while a held
// result is not taken. One beat per cycle is accepted as long as the result
// side keeps taking beats. Configuration writes are always ready and take
// effect on the next cycle; they should be made while no tick is in flight.
module jog_button_multiplier_fsm #(
   parameter int TIMER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_key_down,
   input  logic                          req_spindle_running,
   input  logic                          req_alarm_active,
   input  logic                          req_brake_active,
   input  logic                          req_encoder_moved,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_multiplier_code,
   output logic                          rsp_frozen,
   output logic                          rsp_stop_request,
   output logic                          rsp_display_refresh,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [jbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jbm_pkg::CFG_W-1:0]     csr_wdata
);
   import jbm_pkg::*;

   req_type req_ff;
   logic    in_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type step_rsp;
   cfg_type cfg;
   logic    advance;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   jbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   jbm_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (req_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.key_down        <= req_key_down;
         req_ff.spindle_running <= req_spindle_running;
         req_ff.alarm_active    <= req_alarm_active;
         req_ff.brake_active    <= req_brake_active;
         req_ff.encoder_moved   <= req_encoder_moved;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_multiplier_code = rsp_ff.multiplier_code;
   assign rsp_frozen          = rsp_ff.frozen;
   assign rsp_stop_request    = rsp_ff.stop_request;
   assign rsp_display_refresh = rsp_ff.display_refresh;

endmodule

[sv/jbm_csr.sv]
// ----------------------------------------------------------------------------
// Jog button multiplier configuration registers
// Holds the five timing registers written through the configuration port.
// ----------------------------------------------------------------------------
module jbm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [jbm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [jbm_pkg::CFG_W-1:0]     csr_wdata,
   output jbm_pkg::cfg_type              cfg
);
   import jbm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ms           = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_ms         = csr_wdata;
            CSR_MULT_TMO:   cfg_in.multiplier_timeout_ms = csr_wdata;
            CSR_FREEZE:     cfg_in.freeze_ms             = csr_wdata;
            CSR_CLICK_WIN:  cfg_in.click_window_ms       = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms           <= DEBOUNCE_RST;
         cfg_ff.long_press_ms         <= LONG_PRESS_RST;
         cfg_ff.multiplier_timeout_ms <= MULT_TMO_RST;
         cfg_ff.freeze_ms             <= FREEZE_RST;
         cfg_ff.click_window_ms       <= CLICK_WIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/jbm_core.sv]
// ----------------------------------------------------------------------------
// Jog button multiplier core
// Button debounce state machine, multiplier and freeze timers; steps once per
// tick when fire is high and presents that tick's result combinationally.
// ----------------------------------------------------------------------------
module jbm_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  jbm_pkg::req_type req,
   input  jbm_pkg::cfg_type cfg,
   output jbm_pkg::rsp_type rsp
);
   import jbm_pkg::*;

   localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] btn_el_ff, btn_el_in;
   logic [TIMER_BITS-1:0] mult_el_ff, mult_el_in;
   logic [TIMER_BITS-1:0] frz_el_ff, frz_el_in;
   logic [TIMER_BITS-1:0] since_ff, since_in;
   logic                  last_long_ff, last_long_in;
   logic [1:0]            mult_ff, mult_in;
   logic                  frz_ff, frz_in;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [CMP_W-1:0] ext_t(input logic [TIMER_BITS-1:0] v);
      return CMP_W'(v);
   endfunction

   function automatic logic [CMP_W-1:0] ext_c(input logic [CFG_W-1:0] v);
      return CMP_W'(v);
   endfunction

   always_comb begin
      logic stop;
      logic refresh;
      logic [TIMER_BITS-1:0] gap;

      btn_el_in    = sat_inc(btn_el_ff);
      mult_el_in   = sat_inc(mult_el_ff);
      frz_el_in    = sat_inc(frz_el_ff);
      since_in     = sat_inc(since_ff);
      phase_in     = phase_ff;
      last_long_in = last_long_ff;
      mult_in      = mult_ff;
      frz_in       = frz_ff;
      stop         = 1'b0;
      refresh      = 1'b0;
      gap          = since_ff;

      if (req.encoder_moved && !req.brake_active) begin
         mult_el_in = '0;
      end

      if (frz_ff && (ext_t(frz_el_in) > ext_c(cfg.freeze_ms))) begin
         frz_in = 1'b0;
      end

      if (((mult_ff == MULT_X10) || (mult_ff == MULT_X100)) &&
          (ext_t(mult_el_in) > ext_c(cfg.multiplier_timeout_ms))) begin
         mult_in = MULT_X1;
         refresh = 1'b1;
      end

      case (phase_ff)
         PH_DEB_PRESS: begin
            if (!req.key_down) begin
               phase_in = PH_IDLE;
            end else if (ext_t(btn_el_in) >= ext_c(cfg.debounce_ms)) begin
               phase_in  = PH_PRESSED;
               btn_el_in = '0;
            end
         end
         PH_PRESSED: begin
            if (!req.key_down) begin
               phase_in  = PH_DEB_RELEASE;
               btn_el_in = '0;
            end else if (ext_t(btn_el_in) >= ext_c(cfg.long_press_ms)) begin
               last_long_in = 1'b1;
               stop         = 1'b1;
               mult_in      = MULT_OFF;
               frz_in       = 1'b1;
               frz_el_in    = '0;
               since_in     = '0;
               refresh      = 1'b1;
               phase_in     = PH_LONG;
            end
         end
         PH_LONG: begin
            if (!req.key_down) begin
               phase_in  = PH_DEB_RELEASE;
               btn_el_in = '0;
            end
         end
         PH_DEB_RELEASE: begin
            if (req.key_down) begin
               phase_in = PH_PRESSED;
            end else if (ext_t(btn_el_in) >= ext_c(cfg.debounce_ms)) begin
               phase_in = PH_IDLE;
               if (last_long_ff) begin
                  last_long_in = 1'b0;
               end else if (!req.alarm_active && !req.brake_active) begin
                  // The click gap is the time since the previous click or long press,
                  // taken after this tick's increment.
                  gap      = since_in;
                  since_in = '0;
                  if (req.spindle_running) begin
                     if (!frz_in) begin
                        mult_in = MULT_X1;
                        frz_in  = 1'b1;
                     end else begin
                        mult_in = next_mult(mult_in);
                     end
                     frz_el_in = '0;
                  end else if (ext_t(gap) > ext_c(cfg.click_window_ms)) begin
                     mult_in = MULT_X1;
                  end else begin
                     mult_in = next_mult(mult_in);
                  end
                  mult_el_in = '0;
                  refresh    = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (req.key_down) begin
               phase_in  = PH_DEB_PRESS;
               btn_el_in = '0;
            end
         end
      endcase

      rsp.multiplier_code = mult_in;
      rsp.frozen          = frz_in;
      rsp.stop_request    = stop;
      rsp.display_refresh = refresh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         btn_el_ff    <= '0;
         mult_el_ff   <= '0;
         frz_el_ff    <= '0;
         since_ff     <= '0;
         last_long_ff <= 1'b0;
         mult_ff      <= MULT_X1;
         frz_ff       <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         btn_el_ff    <= btn_el_in;
         mult_el_ff   <= mult_el_in;
         frz_el_ff    <= frz_el_in;
         since_ff     <= since_in;
         last_long_ff <= last_long_in;
         mult_ff      <= mult_in;
         frz_ff       <= frz_in;
      end
   end

endmodule
